// ===== hdl/classifier_frame_metrics_defines.svh =====
// ----------------------------------------------------------------------------
// Classifier frame metrics assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CLASSIFIER_FRAME_METRICS_DEFINES_SVH
`define CLASSIFIER_FRAME_METRICS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CFM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("classifier frame metrics: assertion failed");

// Next-cycle implication.
`define CFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("classifier frame metrics: assertion failed");

`else

`define CFM_ASSERT_IMPL(lbl, ante, cons)
`define CFM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/cfm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfm_pkg
// Types, constants, the -ln table and helper functions of the frame metrics.
// ----------------------------------------------------------------------------
package cfm_pkg;

    localparam int MAX_CLASSES    = 1024;
    localparam int LN_TABLE_DEPTH = 256;

    localparam int POS_W    = $clog2(MAX_CLASSES);
    localparam int LN_IDX_W = $clog2(LN_TABLE_DEPTH);
    localparam int LN_T_W   = 16;

    localparam int Q_W     = 16;
    localparam int LABEL_W = 10;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;
    localparam int K_W     = 4;
    localparam int NL_W    = 26;

    localparam int MUL_A_W = NL_W;
    localparam int MUL_B_W = Q_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int CE_T_W  = MUL_P_W + 1 - 15;

    localparam int IN_W      = 48;
    localparam int OUT_BITS  = 1 + 2 * CNT_W + 2 * SUM_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [Q_W-1:0]  Q15_ONE          = 16'h8000;
    localparam logic [Q_W-1:0]  LN2_Q16          = 16'd45426;
    localparam logic [NL_W-1:0] NEG_LN_FLOOR_Q16 = 26'd45270665;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_LN,
        ST_NL,
        ST_CE,
        ST_ACC,
        ST_END
    } t_state;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_LN2,
        MUL_CE
    } t_mul_sel;

    typedef struct packed {
        logic in_valid;
        logic in_clear;
        logic item_last;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic     ready;
        logic     load;
        logic     clear;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sse_add;
        logic     nl_load;
        logic     ce_add;
        logic     elem_done;
        logic     frame_end;
    } t_ctrl;

    typedef logic [LN_T_W-1:0] t_ln_tab [LN_TABLE_DEPTH];

    // Restoring shift-subtract division, used only while elaborating the table.
    function automatic logic [63:0] f_udiv(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/DEPTH) in Q16 through the atanh series in Q30.
    function automatic t_ln_tab f_build_ln_tab();
        t_ln_tab     tab;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        for (int i = 0; i < LN_TABLE_DEPTH; i++) begin
            z    = f_udiv(64'(i) << 30, 64'(2 * LN_TABLE_DEPTH + i));
            z2   = (z * z) >> 30;
            term = z;
            sum  = '0;
            n    = 64'd1;
            for (int j = 0; j < 64; j++) begin
                if (term != 64'd0) begin
                    sum  = sum + f_udiv(term, n);
                    term = (term * z2) >> 30;
                    n    = n + 64'd2;
                end
            end
            tab[i] = LN_T_W'((64'd2 * sum + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam t_ln_tab LN_TAB = f_build_ln_tab();

    // Leading zeros of a non-zero 16-bit value.
    function automatic logic [K_W-1:0] f_lead_zeros(logic [Q_W-1:0] v);
        logic [K_W-1:0] k;
        logic           found;
        k     = '0;
        found = 1'b0;
        for (int b = Q_W - 1; b >= 0; b--) begin
            if (!found && v[b]) begin
                found = 1'b1;
                k     = K_W'(Q_W - 1 - b);
            end
        end
        return k;
    endfunction

    function automatic logic [SUM_W-1:0] f_sat_add64(logic [SUM_W-1:0] a,
                                                     logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] f_sat_inc32(logic [CNT_W-1:0] a);
        return (a == '1) ? a : a + CNT_W'(1);
    endfunction

endpackage

// ===== hdl/cfm_mult.sv =====
// ----------------------------------------------------------------------------
// cfm_mult
// Shared multiplier with operand selection and a registered product.
// ----------------------------------------------------------------------------
module cfm_mult (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  cfm_pkg::t_mul_sel             i_sel,
    input  logic [cfm_pkg::Q_W-1:0]       i_err_abs,
    input  logic [cfm_pkg::K_W-1:0]       i_k,
    input  logic [cfm_pkg::Q_W-1:0]       i_target,
    input  logic [cfm_pkg::NL_W-1:0]      i_nl,
    output logic [cfm_pkg::MUL_P_W-1:0]   o_prod
);
    import cfm_pkg::*;

    logic [MUL_A_W-1:0] w_a;
    logic [MUL_B_W-1:0] w_b;
    logic [MUL_P_W-1:0] r_prod;

    always_comb begin
        case (i_sel)
            MUL_SQ: begin
                w_a = MUL_A_W'(i_err_abs);
                w_b = i_err_abs;
            end
            MUL_LN2: begin
                w_a = MUL_A_W'(i_k);
                w_b = LN2_Q16;
            end
            MUL_CE: begin
                w_a = i_nl;
                w_b = i_target;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= MUL_P_W'(w_a) * MUL_P_W'(w_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/cfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfm_ctrl
// Sequencer that steps one class element through the shared multiplier.
// ----------------------------------------------------------------------------
`include "classifier_frame_metrics_defines.svh"

module cfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfm_pkg::t_stat i_stat,
    output cfm_pkg::t_ctrl o_ctrl
);
    import cfm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ctrl.mul_sel = MUL_SQ;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.ready = 1'b1;
                if (i_stat.in_valid) begin
                    if (i_stat.in_clear) begin
                        o_ctrl.clear = 1'b1;
                    end else begin
                        o_ctrl.load = 1'b1;
                        n_state     = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_SQ;
                n_state        = ST_LN;
            end
            ST_LN: begin
                o_ctrl.sse_add = 1'b1;
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_LN2;
                n_state        = ST_NL;
            end
            ST_NL: begin
                o_ctrl.nl_load = 1'b1;
                n_state        = ST_CE;
            end
            ST_CE: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_CE;
                n_state        = ST_ACC;
            end
            ST_ACC: begin
                o_ctrl.ce_add    = 1'b1;
                o_ctrl.elem_done = 1'b1;
                n_state          = i_stat.item_last ? ST_END : ST_IDLE;
            end
            ST_END: begin
                if (i_stat.out_free) begin
                    o_ctrl.frame_end = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // An accepted class element always starts the multiply sequence.
    `CFM_ASSERT_NEXT(a_load_starts_sq, (r_state == ST_IDLE) && i_stat.in_valid && !i_stat.in_clear, r_state == ST_SQ)

endmodule

// ===== hdl/classifier_frame_metrics.sv =====
// ----------------------------------------------------------------------------
// classifier_frame_metrics
// Per-frame argmax check, squared error and cross-entropy of classifier scores.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: score, target_value, target_label; tuser: clear;
//                       tlast: last class element of the frame
//  m_axis    out        tdata: frame_wrong, frames_total, errors_total,
//                       sse_total, ce_total (one beat per frame end)
//  cfg       in         target_mode, written when i_cfg_wr_en is high
//
// A class element is accepted in the idle state, then steps through the SQ,
// LN, NL, CE and ACC states: the one shared multiplier forms the squared
// error, the k*ln2 term and the weighted cross-entropy product in turn, each
// registered before use. The last element of a frame then passes the END
// state to commit the frame and load the output register; that state waits
// while an earlier result beat is still held. A clear beat is taken in IDLE.
// Reset is synchronous and active low; it clears all totals and sets the
// target mode to label mode.
// ----------------------------------------------------------------------------
`include "classifier_frame_metrics_defines.svh"

module classifier_frame_metrics (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input beats
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [15:0] score, [31:16] target_value, [41:32] target_label, [47:42] zero
    input  logic [cfm_pkg::IN_W-1:0]    i_s_axis_tdata,
    // [0] kind (1 = clear all statistics)
    input  logic                        i_s_axis_tuser,
    input  logic                        i_s_axis_tlast,
    // Result beats
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [0] frame_wrong, [32:1] frames_total, [64:33] errors_total,
    // [128:65] sse_total, [192:129] ce_total, [199:193] zero
    output logic [cfm_pkg::OUT_W-1:0]   o_m_axis_tdata,
    // Configuration
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data
);
    import cfm_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    // Mode register, label mode after reset.
    logic r_target_mode;

    // Element held while the sequencer works on it.
    logic [Q_W-1:0]      r_score;
    logic [Q_W-1:0]      r_tval;
    logic [LABEL_W-1:0]  r_label;
    logic                r_last;
    logic [Q_W-1:0]      r_err_abs;
    logic [K_W-1:0]      r_k;
    logic [LN_IDX_W-1:0] r_idx;
    logic                r_zero;
    logic [NL_W-1:0]     r_nl;

    // Frame and running statistics.
    logic [POS_W-1:0] r_pos;
    logic [Q_W-1:0]   r_best_s;
    logic [POS_W-1:0] r_best_s_idx;
    logic [Q_W-1:0]   r_best_t;
    logic [POS_W-1:0] r_best_t_idx;
    logic [CNT_W-1:0] r_frames;
    logic [CNT_W-1:0] r_errors;
    logic [SUM_W-1:0] r_sse;
    logic [SUM_W-1:0] r_ce;

    // Output register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic [MUL_P_W-1:0] w_prod;

    // Incoming element, clamped to one and reduced to its target.
    logic [Q_W-1:0]      w_in_score;
    logic [Q_W-1:0]      w_in_tval;
    logic [LABEL_W-1:0]  w_in_label;
    logic                w_in_hit;
    logic [Q_W-1:0]      w_in_t;
    logic [Q_W-1:0]      w_in_err;
    logic [K_W-1:0]      w_in_k;
    logic [Q_W-1:0]      w_in_m;

    logic [LN_T_W-1:0]   w_tab;
    logic [MUL_P_W:0]    w_ce_round;
    logic [CE_T_W-1:0]   w_ce_term;

    logic                w_wrong;
    logic [CNT_W-1:0]    w_frames_next;
    logic [CNT_W-1:0]    w_errors_next;

    assign w_in_label = i_s_axis_tdata[41:32];
    assign w_in_score = (i_s_axis_tdata[15:0] > Q15_ONE) ? Q15_ONE : i_s_axis_tdata[15:0];
    assign w_in_tval  = (i_s_axis_tdata[31:16] > Q15_ONE) ? Q15_ONE : i_s_axis_tdata[31:16];
    assign w_in_hit   = (32'(w_in_label) == 32'(r_pos));

    // In label mode the target is one-hot at the labelled class.
    assign w_in_t   = r_target_mode ? (w_in_hit ? Q15_ONE : '0) : w_in_tval;
    assign w_in_err = (w_in_score >= w_in_t) ? (w_in_score - w_in_t) : (w_in_t - w_in_score);

    // Normalise the score so that bit 15 is set; the bits below index the table.
    assign w_in_k = f_lead_zeros(w_in_score);
    assign w_in_m = w_in_score << w_in_k;

    assign w_stat.in_valid  = i_s_axis_tvalid;
    assign w_stat.in_clear  = i_s_axis_tuser;
    assign w_stat.item_last = r_last;
    assign w_stat.out_free  = !r_out_valid || i_m_axis_tready;

    cfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    cfm_mult u_mult (
        .i_clk     (i_clk),
        .i_en      (w_ctrl.mul_en),
        .i_sel     (w_ctrl.mul_sel),
        .i_err_abs (r_err_abs),
        .i_k       (r_k),
        .i_target  (r_tval),
        .i_nl      (r_nl),
        .o_prod    (w_prod)
    );

    assign o_s_axis_tready = w_ctrl.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_target_mode <= i_cfg_wr_data;
        end
    end

    // Element capture and the -ln step; payload only, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_score   <= w_in_score;
            r_tval    <= w_in_t;
            r_label   <= w_in_label;
            r_last    <= i_s_axis_tlast;
            r_err_abs <= w_in_err;
            r_k       <= w_in_k;
            r_idx     <= w_in_m[Q_W-2 -: LN_IDX_W];
            r_zero    <= (w_in_score == '0);
        end
        if (w_ctrl.nl_load) begin
            if (r_zero) begin
                r_nl <= NEG_LN_FLOOR_Q16;
            end else if (w_prod > MUL_P_W'(w_tab)) begin
                r_nl <= NL_W'(w_prod - MUL_P_W'(w_tab));
            end else begin
                r_nl <= '0;
            end
        end
    end

    assign w_tab = LN_TAB[r_idx];

    // Soft-target weighting, rounded back to Q16. In label mode the target is
    // exactly one, so this gives -ln itself at the labelled class.
    assign w_ce_round = {1'b0, w_prod} + (MUL_P_W + 1)'(1 << 14);
    assign w_ce_term  = w_ce_round[MUL_P_W -: CE_T_W];

    assign w_wrong = r_target_mode ? (32'(r_label) != 32'(r_best_s_idx))
                                   : (r_best_t_idx != r_best_s_idx);
    assign w_frames_next = f_sat_inc32(r_frames);
    assign w_errors_next = w_wrong ? f_sat_inc32(r_errors) : r_errors;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_best_s     <= '0;
            r_best_s_idx <= '0;
            r_best_t     <= '0;
            r_best_t_idx <= '0;
            r_frames     <= '0;
            r_errors     <= '0;
            r_sse        <= '0;
            r_ce         <= '0;
        end else if (w_ctrl.clear) begin
            // A clear also restarts the frame in progress.
            r_pos    <= '0;
            r_frames <= '0;
            r_errors <= '0;
            r_sse    <= '0;
            r_ce     <= '0;
        end else begin
            if (w_ctrl.sse_add) begin
                r_sse <= f_sat_add64(r_sse, SUM_W'(w_prod));
            end
            if (w_ctrl.ce_add && (r_tval != '0)) begin
                r_ce <= f_sat_add64(r_ce, SUM_W'(w_ce_term));
            end
            if (w_ctrl.elem_done) begin
                // First maximum: the opening element of a frame always wins.
                if ((r_pos == '0) || (r_score > r_best_s)) begin
                    r_best_s     <= r_score;
                    r_best_s_idx <= r_pos;
                end
                if ((r_pos == '0) || (r_tval > r_best_t)) begin
                    r_best_t     <= r_tval;
                    r_best_t_idx <= r_pos;
                end
                // Overlong frames share the top class index.
                if (!r_last && (32'(r_pos) < 32'(MAX_CLASSES - 1))) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (w_ctrl.frame_end) begin
                r_frames <= w_frames_next;
                r_errors <= w_errors_next;
                r_pos    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.frame_end) begin
            r_out_data <= OUT_W'({r_ce, r_sse, w_errors_next, w_frames_next, w_wrong});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A reported frame has been counted, and errors never outnumber frames.
    `CFM_ASSERT_IMPL(a_out_frames_nonzero, r_out_valid, r_out_data[32:1] != '0)
    `CFM_ASSERT_IMPL(a_out_err_le_frames, r_out_valid, r_out_data[64:33] <= r_out_data[32:1])
    // Squared error only grows between clears.
    `CFM_ASSERT_NEXT(a_sse_monotonic, !w_ctrl.clear, r_sse >= $past(r_sse))

endmodule
